// File: design/cscq_pkg.sv
package cscq_pkg;

    // table capacities
    localparam int MAX_RECTS    = 64;
    localparam int MAX_VERTICES = 256;
    localparam int MAX_POLYGONS = 32;

    // field widths, coordinates are signed q16.8
    localparam int COORD_W = 24;
    localparam int SIZE_W  = 23;

    // index and count widths
    localparam int RIDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int RCNT_W = $clog2(MAX_RECTS + 1);
    localparam int VIDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int VCNT_W = $clog2(MAX_VERTICES + 1);
    localparam int PIDX_W = (MAX_POLYGONS > 1) ? $clog2(MAX_POLYGONS) : 1;
    localparam int PCNT_W = $clog2(MAX_POLYGONS + 1);

    // arithmetic widths
    localparam int DIFF_W = COORD_W + 1;
    localparam int RD_W   = COORD_W + 2;
    localparam int RP_W   = 2 * RD_W;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int R2_W   = 2 * SIZE_W;
    localparam int WM_W   = PROD_W;
    localparam int WP_W   = 2 * WM_W;

    typedef enum logic [1:0] {
        KIND_RECT   = 2'd0,
        KIND_VERTEX = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_Q_INIT,
        ST_R_CHECK,
        ST_R_CLAMP,
        ST_R_MUL,
        ST_R_CMP,
        ST_P_CHECK,
        ST_P_HEAD,
        ST_P_TEST,
        ST_E_READ,
        ST_E_DIFF,
        ST_E_MUL1,
        ST_E_MUL2,
        ST_E_SUM,
        ST_E_DEC,
        ST_E_WAIT,
        ST_E_NEXT,
        ST_P_END,
        ST_REPLY
    } ctrl_state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LOAD,
        OP_Q_INIT,
        OP_R_READ,
        OP_R_CLAMP,
        OP_R_MUL,
        OP_R_CMP,
        OP_P_READ,
        OP_P_HEAD,
        OP_P_SKIP,
        OP_E_READ,
        OP_E_DIFF,
        OP_E_MUL1,
        OP_E_MUL2,
        OP_E_SUM,
        OP_E_DEC,
        OP_E_WCMP,
        OP_E_NEXT,
        OP_P_END
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic in_is_query;
        logic rect_end;
        logic poly_end;
        logic poly_small;
        logic need_wide;
        logic wide_done;
        logic edge_last;
    } dp_status_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [SIZE_W-1:0]  w;
        logic [SIZE_W-1:0]  h;
        logic               water;
    } rect_entry_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } vert_entry_t;

    typedef struct packed {
        logic [VIDX_W-1:0] first;
        logic [VCNT_W-1:0] size;
        logic              water;
    } poly_entry_t;

endpackage

// File: design/cscq_wmul.sv
module cscq_wmul (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     go,
    input  logic [cscq_pkg::WM_W-1:0] a,
    input  logic [cscq_pkg::WM_W-1:0] b,
    output logic                     done,
    output logic [cscq_pkg::WP_W-1:0] prod
);
    import cscq_pkg::*;

    localparam int DIGIT = 8;
    localparam int STEPS = (WM_W + DIGIT - 1) / DIGIT;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [WP_W-1:0]  a_sh_reg;
    logic [WM_W-1:0]  b_reg;
    logic [WP_W-1:0]  acc_reg;
    logic [WP_W-1:0]  part;
    logic             last_step;

    // one byte of the multiplier per cycle
    assign part      = WP_W'(a_sh_reg * b_reg[DIGIT-1:0]);
    assign last_step = (cnt_reg == CNT_W'(STEPS - 1));

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                    busy_reg <= 1'b0;
            end
        end
    end

    // shift and accumulate
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            a_sh_reg <= WP_W'(a);
            b_reg    <= b;
            acc_reg  <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg  <= acc_reg + part;
            a_sh_reg <= a_sh_reg << DIGIT;
            b_reg    <= b_reg >> DIGIT;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// File: design/cscq_datapath.sv
module cscq_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cscq_pkg::dp_cmd_t             cmd,
    output cscq_pkg::dp_status_t          st,
    input  logic [1:0]                    kind,
    input  logic                          layer,
    input  logic signed [cscq_pkg::COORD_W-1:0] pos_x,
    input  logic signed [cscq_pkg::COORD_W-1:0] pos_y,
    input  logic signed [cscq_pkg::COORD_W-1:0] offset_x,
    input  logic signed [cscq_pkg::COORD_W-1:0] offset_y,
    input  logic [cscq_pkg::SIZE_W-1:0]   rect_width,
    input  logic [cscq_pkg::SIZE_W-1:0]   rect_height,
    input  logic [cscq_pkg::SIZE_W-1:0]   radius,
    input  logic                          last_vertex,
    output logic                          status,
    output logic                          hits_obstacle,
    output logic                          near_water
);
    import cscq_pkg::*;

    localparam int MUL_N         = 6;
    localparam int MIN_EDGE_SIZE = 2;
    localparam int MIN_AREA_SIZE = 3;

    function automatic logic [COORD_W-1:0] sat_coord(input logic signed [DIFF_W-1:0] v);
        logic signed [DIFF_W-1:0] hi;
        logic signed [DIFF_W-1:0] lo;
        hi = DIFF_W'((1 << (COORD_W - 1)) - 1);
        lo = -hi - DIFF_W'(1);
        if (v > hi)
            sat_coord = hi[COORD_W-1:0];
        else if (v < lo)
            sat_coord = lo[COORD_W-1:0];
        else
            sat_coord = v[COORD_W-1:0];
    endfunction

    // captured item
    kind_t                      kind_reg;
    logic                       layer_reg;
    logic signed [COORD_W-1:0]  px_reg;
    logic signed [COORD_W-1:0]  py_reg;
    logic signed [COORD_W-1:0]  ox_reg;
    logic signed [COORD_W-1:0]  oy_reg;
    logic [SIZE_W-1:0]          w_reg;
    logic [SIZE_W-1:0]          h_reg;
    logic [SIZE_W-1:0]          rad_reg;
    logic                       last_reg;

    // table state
    logic [RCNT_W-1:0] rect_count_reg;
    logic [VCNT_W-1:0] vert_count_reg;
    logic [PCNT_W-1:0] poly_count_reg;
    logic              open_reg;
    logic [VIDX_W-1:0] cur_first_reg;
    logic [VCNT_W-1:0] cur_size_reg;
    logic              cur_water_reg;

    // result flags
    logic status_reg;
    logic hit_reg;
    logic wet_reg;

    // query walk
    logic [R2_W-1:0]   r2_reg;
    logic [RCNT_W-1:0] k_reg;
    logic [PCNT_W-1:0] p_reg;
    rect_entry_t       rect_rd_reg;
    poly_entry_t       poly_rd_reg;
    vert_entry_t       va_reg;
    vert_entry_t       vb_reg;
    logic signed [RD_W-1:0] rdx_reg;
    logic signed [RD_W-1:0] rdy_reg;
    logic [VIDX_W-1:0] pf_reg;
    logic [VCNT_W-1:0] ps_reg;
    logic              pw_reg;
    logic [VCNT_W-1:0] e_reg;
    logic [VIDX_W-1:0] i_idx_reg;
    logic [VIDX_W-1:0] j_idx_reg;
    logic signed [DIFF_W-1:0] dx_reg;
    logic signed [DIFF_W-1:0] dy_reg;
    logic signed [DIFF_W-1:0] ax_reg;
    logic signed [DIFF_W-1:0] ay_reg;
    logic signed [DIFF_W-1:0] bx_reg;
    logic signed [DIFF_W-1:0] by_reg;
    logic                     cross_reg;
    logic signed [RP_W-1:0]   m_reg [MUL_N];
    logic signed [SUM_W-1:0]  den_reg;
    logic signed [SUM_W-1:0]  num_reg;
    logic signed [SUM_W-1:0]  cr_reg;
    logic signed [SUM_W-1:0]  da_reg;
    logic signed [SUM_W-1:0]  db_reg;
    logic                     toggle_reg;
    logic                     edge_hit_reg;
    logic                     any_reg;
    logic                     in_reg;

    // memories
    rect_entry_t rect_mem [MAX_RECTS];
    vert_entry_t vert_mem [MAX_VERTICES];
    poly_entry_t poly_mem [MAX_POLYGONS];

    logic        rect_we;
    logic        vert_we;
    logic        poly_we;
    logic [PIDX_W-1:0] poly_wa;
    poly_entry_t poly_wd;
    vert_entry_t vert_wd;
    logic        rect_full;
    logic        vert_full;
    logic [PCNT_W-1:0] poly_prev;

    // shared multipliers
    logic signed [RD_W-1:0] mul_a [MUL_N];
    logic signed [RD_W-1:0] mul_b [MUL_N];
    logic signed [RP_W-1:0] prod  [MUL_N];

    logic signed [COORD_W-1:0] rx0;
    logic signed [COORD_W-1:0] ry0;
    logic signed [DIFF_W-1:0]  rx1;
    logic signed [DIFF_W-1:0]  ry1;
    logic signed [DIFF_W-1:0]  cx;
    logic signed [DIFF_W-1:0]  cy;
    logic signed [DIFF_W-1:0]  pxe;
    logic signed [DIFF_W-1:0]  pye;
    logic signed [COORD_W-1:0] xa;
    logic signed [COORD_W-1:0] ya;
    logic signed [COORD_W-1:0] xb;
    logic signed [COORD_W-1:0] yb;
    logic signed [RP_W-1:0]    rect_sum;
    logic signed [RP_W-1:0]    rect_r2;
    logic signed [SUM_W-1:0]   edge_r2;
    logic [WM_W-1:0]           cr_abs;
    logic                      need_wide;
    logic                      wide_go;
    logic                      wa_done;
    logic                      wb_done;
    logic [WP_W-1:0]           wa_prod;
    logic [WP_W-1:0]           wb_prod;

    // load decode
    assign rect_full = (rect_count_reg >= RCNT_W'(MAX_RECTS));
    assign vert_full = (vert_count_reg >= VCNT_W'(MAX_VERTICES))
                    || (!open_reg && (poly_count_reg >= PCNT_W'(MAX_POLYGONS)));
    assign poly_prev = poly_count_reg - 1'b1;
    assign vert_wd.x = sat_coord(DIFF_W'(px_reg) + DIFF_W'(ox_reg));
    assign vert_wd.y = sat_coord(DIFF_W'(py_reg) - DIFF_W'(oy_reg));

    always_comb
    begin
        rect_we       = 1'b0;
        vert_we       = 1'b0;
        poly_we       = 1'b0;
        poly_wa       = poly_count_reg[PIDX_W-1:0];
        poly_wd.first = vert_count_reg[VIDX_W-1:0];
        poly_wd.size  = VCNT_W'(1);
        poly_wd.water = layer_reg;
        if (cmd.op == OP_LOAD)
        begin
            if (kind_reg == KIND_RECT)
                rect_we = !rect_full;
            if (kind_reg == KIND_VERTEX && !vert_full)
            begin
                vert_we = 1'b1;
                poly_we = 1'b1;
                if (open_reg)
                begin
                    poly_wa       = poly_prev[PIDX_W-1:0];
                    poly_wd.first = cur_first_reg;
                    poly_wd.size  = cur_size_reg + 1'b1;
                    poly_wd.water = cur_water_reg;
                end
            end
        end
    end

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (rect_we)
            rect_mem[rect_count_reg[RIDX_W-1:0]] <= '{x: px_reg, y: py_reg, w: w_reg,
                                                     h: h_reg, water: layer_reg};
        if (cmd.op == OP_R_READ)
            rect_rd_reg <= rect_mem[k_reg[RIDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (vert_we)
            vert_mem[vert_count_reg[VIDX_W-1:0]] <= vert_wd;
        if (cmd.op == OP_E_READ)
        begin
            va_reg <= vert_mem[j_idx_reg];
            vb_reg <= vert_mem[i_idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (poly_we)
            poly_mem[poly_wa] <= poly_wd;
        if (cmd.op == OP_P_READ)
            poly_rd_reg <= poly_mem[p_reg[PIDX_W-1:0]];
    end

    // rectangle clamp
    assign rx0 = $signed(rect_rd_reg.x);
    assign ry0 = $signed(rect_rd_reg.y);
    assign rx1 = DIFF_W'(rx0) + $signed(DIFF_W'(rect_rd_reg.w));
    assign ry1 = DIFF_W'(ry0) + $signed(DIFF_W'(rect_rd_reg.h));
    assign pxe = DIFF_W'(px_reg);
    assign pye = DIFF_W'(py_reg);

    always_comb
    begin
        if (pxe < DIFF_W'(rx0))
            cx = DIFF_W'(rx0);
        else if (pxe > rx1)
            cx = rx1;
        else
            cx = pxe;
        if (pye < DIFF_W'(ry0))
            cy = DIFF_W'(ry0);
        else if (pye > ry1)
            cy = ry1;
        else
            cy = pye;
    end

    // edge endpoints
    assign xa = $signed(va_reg.x);
    assign ya = $signed(va_reg.y);
    assign xb = $signed(vb_reg.x);
    assign yb = $signed(vb_reg.y);

    // multiplier operand select
    always_comb
    begin
        for (int n = 0; n < MUL_N; n++)
        begin
            mul_a[n] = '0;
            mul_b[n] = '0;
        end
        case (cmd.op)
            OP_R_MUL:
            begin
                mul_a[0] = rdx_reg;           mul_b[0] = rdx_reg;
                mul_a[1] = rdy_reg;           mul_b[1] = rdy_reg;
            end
            OP_E_MUL1:
            begin
                mul_a[0] = RD_W'(dx_reg);     mul_b[0] = RD_W'(dx_reg);
                mul_a[1] = RD_W'(dy_reg);     mul_b[1] = RD_W'(dy_reg);
                mul_a[2] = RD_W'(ax_reg);     mul_b[2] = RD_W'(dx_reg);
                mul_a[3] = RD_W'(ay_reg);     mul_b[3] = RD_W'(dy_reg);
                mul_a[4] = RD_W'(ax_reg);     mul_b[4] = RD_W'(dy_reg);
                mul_a[5] = RD_W'(ay_reg);     mul_b[5] = RD_W'(dx_reg);
            end
            OP_E_MUL2:
            begin
                mul_a[0] = RD_W'(ax_reg);     mul_b[0] = RD_W'(ax_reg);
                mul_a[1] = RD_W'(ay_reg);     mul_b[1] = RD_W'(ay_reg);
                mul_a[2] = RD_W'(bx_reg);     mul_b[2] = RD_W'(bx_reg);
                mul_a[3] = RD_W'(by_reg);     mul_b[3] = RD_W'(by_reg);
                mul_a[4] = RD_W'(bx_reg);     mul_b[4] = RD_W'(dy_reg);
                mul_a[5] = RD_W'(dx_reg);     mul_b[5] = RD_W'(by_reg);
            end
            default:
            begin
            end
        endcase
        for (int n = 0; n < MUL_N; n++)
            prod[n] = mul_a[n] * mul_b[n];
    end

    // distance compares
    assign rect_sum  = m_reg[0] + m_reg[1];
    assign rect_r2   = $signed(RP_W'(r2_reg));
    assign edge_r2   = $signed(SUM_W'(r2_reg));
    assign cr_abs    = WM_W'(cr_reg < 0 ? -cr_reg : cr_reg);
    assign need_wide = (den_reg != '0) && (num_reg > 0) && (num_reg < den_reg);
    assign wide_go   = (cmd.op == OP_E_DEC) && need_wide;

    // perpendicular distance: cross squared against radius squared times length squared
    cscq_wmul u_wmul_cross (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (wide_go),
        .a     (cr_abs),
        .b     (cr_abs),
        .done  (wa_done),
        .prod  (wa_prod)
    );

    cscq_wmul u_wmul_bound (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (wide_go),
        .a     (WM_W'(r2_reg)),
        .b     (WM_W'(den_reg)),
        .done  (wb_done),
        .prod  (wb_prod)
    );

    // table state and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_count_reg <= '0;
            vert_count_reg <= '0;
            poly_count_reg <= '0;
            open_reg       <= 1'b0;
            status_reg     <= 1'b0;
            hit_reg        <= 1'b0;
            wet_reg        <= 1'b0;
            k_reg          <= '0;
            p_reg          <= '0;
        end
        else
        begin
            unique case (cmd.op)
                OP_LOAD:
                begin
                    status_reg <= 1'b0;
                    hit_reg    <= 1'b0;
                    wet_reg    <= 1'b0;
                    unique case (kind_reg)
                        KIND_RECT:
                        begin
                            if (rect_full)
                                status_reg <= 1'b1;
                            else
                                rect_count_reg <= rect_count_reg + 1'b1;
                        end
                        KIND_VERTEX:
                        begin
                            if (vert_full)
                                status_reg <= 1'b1;
                            else
                            begin
                                vert_count_reg <= vert_count_reg + 1'b1;
                                if (!open_reg)
                                begin
                                    poly_count_reg <= poly_count_reg + 1'b1;
                                    open_reg       <= 1'b1;
                                end
                            end
                            if (last_reg)
                                open_reg <= 1'b0;
                        end
                        KIND_CLEAR:
                        begin
                            rect_count_reg <= '0;
                            vert_count_reg <= '0;
                            poly_count_reg <= '0;
                            open_reg       <= 1'b0;
                        end
                        KIND_QUERY:
                        begin
                        end
                    endcase
                end
                OP_Q_INIT:
                begin
                    status_reg <= 1'b0;
                    hit_reg    <= 1'b0;
                    wet_reg    <= 1'b0;
                    k_reg      <= '0;
                    p_reg      <= '0;
                end
                OP_R_CMP:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (rect_sum <= rect_r2)
                    begin
                        hit_reg <= 1'b1;
                        if (rect_rd_reg.water)
                            wet_reg <= 1'b1;
                    end
                end
                OP_P_SKIP:
                    p_reg <= p_reg + 1'b1;
                OP_P_END:
                begin
                    p_reg <= p_reg + 1'b1;
                    if (pw_reg && any_reg)
                        wet_reg <= 1'b1;
                    if ((ps_reg >= VCNT_W'(MIN_AREA_SIZE)) && (in_reg || any_reg))
                        hit_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // open polygon tracking
    always_ff @(posedge clk)
    begin
        if (poly_we)
        begin
            cur_first_reg <= poly_wd.first;
            cur_size_reg  <= poly_wd.size;
            cur_water_reg <= poly_wd.water;
        end
    end

    // item capture and query arithmetic
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CAPTURE:
            begin
                kind_reg  <= kind_t'(kind);
                layer_reg <= layer;
                px_reg    <= pos_x;
                py_reg    <= pos_y;
                ox_reg    <= offset_x;
                oy_reg    <= offset_y;
                w_reg     <= rect_width;
                h_reg     <= rect_height;
                rad_reg   <= radius;
                last_reg  <= last_vertex;
            end
            OP_Q_INIT:
                r2_reg <= R2_W'(rad_reg * rad_reg);
            OP_R_CLAMP:
            begin
                rdx_reg <= RD_W'(pxe) - RD_W'(cx);
                rdy_reg <= RD_W'(pye) - RD_W'(cy);
            end
            OP_R_MUL:
                for (int n = 0; n < MUL_N; n++)
                    m_reg[n] <= prod[n];
            OP_P_HEAD:
            begin
                pf_reg    <= poly_rd_reg.first;
                ps_reg    <= poly_rd_reg.size;
                pw_reg    <= poly_rd_reg.water;
                e_reg     <= '0;
                i_idx_reg <= poly_rd_reg.first;
                j_idx_reg <= VIDX_W'(VCNT_W'(poly_rd_reg.first) + poly_rd_reg.size - 1'b1);
                any_reg   <= 1'b0;
                in_reg    <= 1'b0;
            end
            OP_E_DIFF:
            begin
                dx_reg    <= DIFF_W'(xb) - DIFF_W'(xa);
                dy_reg    <= DIFF_W'(yb) - DIFF_W'(ya);
                ax_reg    <= pxe - DIFF_W'(xa);
                ay_reg    <= pye - DIFF_W'(ya);
                bx_reg    <= pxe - DIFF_W'(xb);
                by_reg    <= pye - DIFF_W'(yb);
                cross_reg <= (yb > py_reg) != (ya > py_reg);
            end
            OP_E_MUL1:
                for (int n = 0; n < MUL_N; n++)
                    m_reg[n] <= prod[n];
            OP_E_MUL2:
            begin
                den_reg <= SUM_W'(m_reg[0] + m_reg[1]);
                num_reg <= SUM_W'(m_reg[2] + m_reg[3]);
                cr_reg  <= SUM_W'(m_reg[4] - m_reg[5]);
                for (int n = 0; n < MUL_N; n++)
                    m_reg[n] <= prod[n];
            end
            OP_E_SUM:
            begin
                da_reg <= SUM_W'(m_reg[0] + m_reg[1]);
                db_reg <= SUM_W'(m_reg[2] + m_reg[3]);
                // crossing to the right of the centre flips parity
                if (dy_reg < 0)
                    toggle_reg <= cross_reg && (m_reg[4] > m_reg[5]);
                else
                    toggle_reg <= cross_reg && (m_reg[4] < m_reg[5]);
            end
            OP_E_DEC:
            begin
                if (den_reg == '0)
                    edge_hit_reg <= 1'b0;
                else if (num_reg <= 0)
                    edge_hit_reg <= (da_reg <= edge_r2);
                else if (num_reg >= den_reg)
                    edge_hit_reg <= (db_reg <= edge_r2);
                else
                    edge_hit_reg <= 1'b0;
            end
            OP_E_WCMP:
                edge_hit_reg <= (wa_prod <= wb_prod);
            OP_E_NEXT:
            begin
                any_reg   <= any_reg || edge_hit_reg;
                in_reg    <= in_reg ^ toggle_reg;
                e_reg     <= e_reg + 1'b1;
                j_idx_reg <= i_idx_reg;
                i_idx_reg <= i_idx_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // status to the controller
    assign st.in_is_query = (kind_t'(kind) == KIND_QUERY);
    assign st.rect_end    = (k_reg >= rect_count_reg);
    assign st.poly_end    = (p_reg >= poly_count_reg);
    assign st.poly_small  = (ps_reg < VCNT_W'(MIN_EDGE_SIZE));
    assign st.need_wide   = need_wide;
    assign st.wide_done   = wa_done && wb_done;
    assign st.edge_last   = (e_reg == ps_reg - 1'b1);

    assign status        = status_reg;
    assign hits_obstacle = hit_reg;
    assign near_water    = wet_reg;

endmodule

// File: design/cscq_ctrl.sv
module cscq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 done,
    output cscq_pkg::dp_cmd_t    cmd,
    input  cscq_pkg::dp_status_t st
);
    import cscq_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // sequencing
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        busy       = (state_reg != ST_IDLE);
        done       = (state_reg == ST_REPLY);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = st.in_is_query ? ST_Q_INIT : ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.op     = OP_LOAD;
                state_next = ST_REPLY;
            end
            ST_Q_INIT:
            begin
                cmd.op     = OP_Q_INIT;
                state_next = ST_R_CHECK;
            end
            ST_R_CHECK:
            begin
                if (st.rect_end)
                    state_next = ST_P_CHECK;
                else
                begin
                    cmd.op     = OP_R_READ;
                    state_next = ST_R_CLAMP;
                end
            end
            ST_R_CLAMP:
            begin
                cmd.op     = OP_R_CLAMP;
                state_next = ST_R_MUL;
            end
            ST_R_MUL:
            begin
                cmd.op     = OP_R_MUL;
                state_next = ST_R_CMP;
            end
            ST_R_CMP:
            begin
                cmd.op     = OP_R_CMP;
                state_next = ST_R_CHECK;
            end
            ST_P_CHECK:
            begin
                if (st.poly_end)
                    state_next = ST_REPLY;
                else
                begin
                    cmd.op     = OP_P_READ;
                    state_next = ST_P_HEAD;
                end
            end
            ST_P_HEAD:
            begin
                cmd.op     = OP_P_HEAD;
                state_next = ST_P_TEST;
            end
            ST_P_TEST:
            begin
                if (st.poly_small)
                begin
                    cmd.op     = OP_P_SKIP;
                    state_next = ST_P_CHECK;
                end
                else
                    state_next = ST_E_READ;
            end
            ST_E_READ:
            begin
                cmd.op     = OP_E_READ;
                state_next = ST_E_DIFF;
            end
            ST_E_DIFF:
            begin
                cmd.op     = OP_E_DIFF;
                state_next = ST_E_MUL1;
            end
            ST_E_MUL1:
            begin
                cmd.op     = OP_E_MUL1;
                state_next = ST_E_MUL2;
            end
            ST_E_MUL2:
            begin
                cmd.op     = OP_E_MUL2;
                state_next = ST_E_SUM;
            end
            ST_E_SUM:
            begin
                cmd.op     = OP_E_SUM;
                state_next = ST_E_DEC;
            end
            ST_E_DEC:
            begin
                cmd.op     = OP_E_DEC;
                state_next = st.need_wide ? ST_E_WAIT : ST_E_NEXT;
            end
            ST_E_WAIT:
            begin
                if (st.wide_done)
                begin
                    cmd.op     = OP_E_WCMP;
                    state_next = ST_E_NEXT;
                end
            end
            ST_E_NEXT:
            begin
                cmd.op     = OP_E_NEXT;
                state_next = st.edge_last ? ST_P_END : ST_E_READ;
            end
            ST_P_END:
            begin
                cmd.op     = OP_P_END;
                state_next = ST_P_CHECK;
            end
            ST_REPLY:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe longer than one cycle");

    a_wait_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_E_WAIT) |-> ($past(state_reg) == ST_E_DEC
                                   || $past(state_reg) == ST_E_WAIT))
        else $error("multiplier wait entered without a start");
`endif

endmodule

// File: design/circle_shape_collision_query_core.sv
// channel  | signals                                     | handshake
// ---------+---------------------------------------------+--------------------------------
// item in  | kind layer pos_x pos_y offset_x offset_y    | taken when start and !busy
//          | rect_width rect_height radius last_vertex   |
// result   | status hits_obstacle near_water             | valid for the one cycle of done
//
// a load or clear is captured, applied in the load state, and answered with the done strobe
// a query checks every rectangle, then each polygon edge by edge; an edge whose
// nearest point lies inside the segment also waits for the shift-add multipliers,
// which take one byte a cycle
// reset clears the shape counts and the sequencer; table contents are left as they are
// busy stays high until done; the receiver takes every result and cannot stall
module circle_shape_collision_query_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          kind,
    input  logic                                layer,
    input  logic signed [cscq_pkg::COORD_W-1:0] pos_x,
    input  logic signed [cscq_pkg::COORD_W-1:0] pos_y,
    input  logic signed [cscq_pkg::COORD_W-1:0] offset_x,
    input  logic signed [cscq_pkg::COORD_W-1:0] offset_y,
    input  logic [cscq_pkg::SIZE_W-1:0]         rect_width,
    input  logic [cscq_pkg::SIZE_W-1:0]         rect_height,
    input  logic [cscq_pkg::SIZE_W-1:0]         radius,
    input  logic                                last_vertex,
    output logic                                done,
    output logic                                status,
    output logic                                hits_obstacle,
    output logic                                near_water
);
    import cscq_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t st;

    // sequencer
    cscq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .st    (st)
    );

    // tables and arithmetic
    cscq_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .kind          (kind),
        .layer         (layer),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .offset_x      (offset_x),
        .offset_y      (offset_y),
        .rect_width    (rect_width),
        .rect_height   (rect_height),
        .radius        (radius),
        .last_vertex   (last_vertex),
        .status        (status),
        .hits_obstacle (hits_obstacle),
        .near_water    (near_water)
    );

endmodule

// File: tb/testbench.sv
module testbench;
    import cscq_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int IDLE_LIMIT  = 40000;
    localparam int ITEM_TARGET = 900;

    typedef struct {
        kind_t       kind;
        bit          layer;
        bit [23:0]   pos_x;
        bit [23:0]   pos_y;
        bit [23:0]   offset_x;
        bit [23:0]   offset_y;
        bit [22:0]   rect_width;
        bit [22:0]   rect_height;
        bit [22:0]   radius;
        bit          last_vertex;
    } item_t;

    typedef struct {
        item_t    it;
        bit       typed;
        bit [2:0] want;
    } row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [1:0]                kind;
    logic                      layer;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] offset_x;
    logic signed [COORD_W-1:0] offset_y;
    logic [SIZE_W-1:0]         rect_width;
    logic [SIZE_W-1:0]         rect_height;
    logic [SIZE_W-1:0]         radius;
    logic                      last_vertex;
    logic                      done;
    logic                      status;
    logic                      hits_obstacle;
    logic                      near_water;

    // shadow copy of the shape tables
    longint    sh_rx[MAX_RECTS];
    longint    sh_ry[MAX_RECTS];
    longint    sh_rw[MAX_RECTS];
    longint    sh_rh[MAX_RECTS];
    bit        sh_rwet[MAX_RECTS];
    int        sh_nrect;
    longint    sh_vx[MAX_VERTICES];
    longint    sh_vy[MAX_VERTICES];
    int        sh_nvert;
    int        sh_pfirst[MAX_POLYGONS];
    int        sh_psize[MAX_POLYGONS];
    bit        sh_pwet[MAX_POLYGONS];
    int        sh_npoly;
    bit        sh_open;

    // expected flags {status, hits_obstacle, near_water}, oldest first
    bit [2:0]  pending_flags[$];
    row_t      directed_rows[$];
    int        errors;
    int        idle_cycles;
    int        n_items;
    int        n_queries;
    int        n_hits;
    int        n_wet;
    int        n_drops;
    int        n_results;

    circle_shape_collision_query_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .layer         (layer),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .offset_x      (offset_x),
        .offset_y      (offset_y),
        .rect_width    (rect_width),
        .rect_height   (rect_height),
        .radius        (radius),
        .last_vertex   (last_vertex),
        .done          (done),
        .status        (status),
        .hits_obstacle (hits_obstacle),
        .near_water    (near_water)
    );

    // clock
    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    function automatic longint clip_coord(longint v);
        longint hi;
        longint lo;
        hi = 64'sd8388607;
        lo = -64'sd8388608;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function automatic bit rect_touch(int k, longint px, longint py, longint r2);
        longint cx;
        longint cy;
        cx = (px < sh_rx[k]) ? sh_rx[k] : ((px > sh_rx[k] + sh_rw[k]) ? sh_rx[k] + sh_rw[k] : px);
        cy = (py < sh_ry[k]) ? sh_ry[k] : ((py > sh_ry[k] + sh_rh[k]) ? sh_ry[k] + sh_rh[k] : py);
        return (px - cx) * (px - cx) + (py - cy) * (py - cy) <= r2;
    endfunction

    // segment distance from vertex a to vertex b against the radius
    function automatic bit seg_touch(int a, int b, longint px, longint py, longint r2);
        longint       dx;
        longint       dy;
        longint       ax;
        longint       ay;
        longint       den;
        longint       num;
        longint       bx;
        longint       by;
        longint       cr;
        logic [127:0] lhs;
        logic [127:0] rhs;
        dx  = sh_vx[b] - sh_vx[a];
        dy  = sh_vy[b] - sh_vy[a];
        ax  = px - sh_vx[a];
        ay  = py - sh_vy[a];
        den = dx * dx + dy * dy;
        if (den == 0)
            return 1'b0;
        num = ax * dx + ay * dy;
        if (num <= 0)
            return ax * ax + ay * ay <= r2;
        if (num >= den)
        begin
            bx = px - sh_vx[b];
            by = py - sh_vy[b];
            return bx * bx + by * by <= r2;
        end
        cr  = ax * dy - ay * dx;
        if (cr < 0)
            cr = -cr;
        lhs = 128'(cr) * 128'(cr);
        rhs = 128'(r2) * 128'(den);
        return lhs <= rhs;
    endfunction

    function automatic bit poly_contains(int p, longint px, longint py);
        int     f;
        int     j;
        bit     in_flag;
        longint yi;
        longint yj;
        longint d;
        longint lhs;
        longint rhs;
        f       = sh_pfirst[p];
        j       = f + sh_psize[p] - 1;
        in_flag = 1'b0;
        for (int i = f; i < f + sh_psize[p]; i++)
        begin
            yi = sh_vy[i];
            yj = sh_vy[j];
            if ((yi > py) != (yj > py))
            begin
                d   = yj - yi;
                lhs = (px - sh_vx[i]) * d;
                rhs = (sh_vx[j] - sh_vx[i]) * (py - yi);
                if (d > 0 ? lhs < rhs : lhs > rhs)
                    in_flag = !in_flag;
            end
            j = i;
        end
        return in_flag;
    endfunction

    function automatic bit poly_border_touch(int p, longint px, longint py, longint r2);
        int f;
        int j;
        f = sh_pfirst[p];
        j = f + sh_psize[p] - 1;
        for (int i = f; i < f + sh_psize[p]; i++)
        begin
            if (seg_touch(j, i, px, py, r2))
                return 1'b1;
            j = i;
        end
        return 1'b0;
    endfunction

    // predicted flags for one item, with the shape tables updated
    function automatic bit [2:0] collide_predict(item_t it);
        bit     drop;
        bit     hit;
        bit     wet;
        longint px;
        longint py;
        longint r2;
        drop = 1'b0;
        hit  = 1'b0;
        wet  = 1'b0;
        px   = longint'(signed'(it.pos_x));
        py   = longint'(signed'(it.pos_y));
        case (it.kind)
            KIND_RECT:
            begin
                if (sh_nrect >= MAX_RECTS)
                    drop = 1'b1;
                else
                begin
                    sh_rx[sh_nrect]   = px;
                    sh_ry[sh_nrect]   = py;
                    sh_rw[sh_nrect]   = longint'(it.rect_width);
                    sh_rh[sh_nrect]   = longint'(it.rect_height);
                    sh_rwet[sh_nrect] = it.layer;
                    sh_nrect++;
                end
            end
            KIND_VERTEX:
            begin
                if (sh_nvert >= MAX_VERTICES || (!sh_open && sh_npoly >= MAX_POLYGONS))
                    drop = 1'b1;
                else
                begin
                    if (!sh_open)
                    begin
                        sh_pfirst[sh_npoly] = sh_nvert;
                        sh_psize[sh_npoly]  = 0;
                        sh_pwet[sh_npoly]   = it.layer;
                        sh_npoly++;
                        sh_open = 1'b1;
                    end
                    sh_vx[sh_nvert] = clip_coord(px + longint'(signed'(it.offset_x)));
                    sh_vy[sh_nvert] = clip_coord(py - longint'(signed'(it.offset_y)));
                    sh_nvert++;
                    sh_psize[sh_npoly-1]++;
                end
                if (it.last_vertex)
                    sh_open = 1'b0;
            end
            KIND_QUERY:
            begin
                r2 = longint'(it.radius) * longint'(it.radius);
                for (int k = 0; k < sh_nrect; k++)
                begin
                    if (rect_touch(k, px, py, r2))
                    begin
                        hit = 1'b1;
                        if (sh_rwet[k])
                            wet = 1'b1;
                    end
                end
                for (int k = 0; k < sh_npoly; k++)
                begin
                    if (sh_psize[k] < 2)
                        continue;
                    if (sh_pwet[k] && !wet && poly_border_touch(k, px, py, r2))
                        wet = 1'b1;
                    if (!hit && sh_psize[k] >= 3 &&
                        (poly_contains(k, px, py) || poly_border_touch(k, px, py, r2)))
                        hit = 1'b1;
                end
            end
            default:
            begin
                sh_nrect = 0;
                sh_nvert = 0;
                sh_npoly = 0;
                sh_open  = 1'b0;
            end
        endcase
        return {drop, hit, wet};
    endfunction

    function automatic item_t mk(kind_t k, bit lay, int px, int py, int ox, int oy,
                                 int w, int h, int r, bit last);
        item_t it;
        it.kind        = k;
        it.layer       = lay;
        it.pos_x       = px[23:0];
        it.pos_y       = py[23:0];
        it.offset_x    = ox[23:0];
        it.offset_y    = oy[23:0];
        it.rect_width  = w[22:0];
        it.rect_height = h[22:0];
        it.radius      = r[22:0];
        it.last_vertex = last;
        return it;
    endfunction

    function automatic item_t noise_item();
        item_t it;
        it.kind        = kind_t'($urandom_range(0, 3));
        it.layer       = $urandom;
        it.pos_x       = $urandom;
        it.pos_y       = $urandom;
        it.offset_x    = $urandom;
        it.offset_y    = $urandom;
        it.rect_width  = $urandom;
        it.rect_height = $urandom;
        it.radius      = $urandom;
        it.last_vertex = $urandom;
        return it;
    endfunction

    function automatic int near_coord();
        return int'($urandom_range(0, 32768)) - 16384;
    endfunction

    function automatic int jitter();
        return int'($urandom_range(0, 2048)) - 1024;
    endfunction

    // pause length in cycles, mostly short with a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // present one item, wait for it to be taken, then idle for gap cycles
    task automatic issue_item(input item_t it, input bit typed, input bit [2:0] want,
                              input int gap);
        bit [2:0] pred;
        start       <= 1'b1;
        kind        <= it.kind;
        layer       <= it.layer;
        pos_x       <= it.pos_x;
        pos_y       <= it.pos_y;
        offset_x    <= it.offset_x;
        offset_y    <= it.offset_y;
        rect_width  <= it.rect_width;
        rect_height <= it.rect_height;
        radius      <= it.radius;
        last_vertex <= it.last_vertex;
        do
            @(posedge clk);
        while (busy);
        pred = collide_predict(it);
        pending_flags.push_back(typed ? want : pred);
        n_items++;
        if (it.kind == KIND_QUERY)
            n_queries++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic issue(input item_t it);
        issue_item(it, 1'b0, 3'b000, pick_gap());
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_flags.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // query centred near a stored corner or vertex, otherwise anywhere close in
    task automatic probe_near();
        int px;
        int py;
        int r;
        int sel;
        sel = $urandom_range(0, 2);
        if (sel == 0 && sh_nrect > 0)
        begin
            r  = $urandom_range(0, sh_nrect - 1);
            px = int'(sh_rx[r]) + jitter() + (($urandom_range(0, 1) != 0) ? int'(sh_rw[r]) : 0);
            py = int'(sh_ry[r]) + jitter() + (($urandom_range(0, 1) != 0) ? int'(sh_rh[r]) : 0);
        end
        else if (sel == 1 && sh_nvert > 0)
        begin
            r  = $urandom_range(0, sh_nvert - 1);
            px = int'(sh_vx[r]) + jitter();
            py = int'(sh_vy[r]) + jitter();
        end
        else
        begin
            px = near_coord();
            py = near_coord();
        end
        r = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 8388607))
                                        : int'($urandom_range(0, 4096));
        issue(mk(KIND_QUERY, $urandom, px, py, near_coord(), near_coord(),
                 $urandom_range(0, 8388607), $urandom_range(0, 8388607), r, $urandom));
    endtask

    task automatic load_rect();
        issue(mk(KIND_RECT, $urandom, near_coord(), near_coord(), $urandom, $urandom,
                 $urandom_range(0, 4096), $urandom_range(0, 4096), $urandom, $urandom));
    endtask

    // polygon drawn round an origin, mostly closed on its last vertex (the last flag is sometimes flipped)
    task automatic load_polygon(input int nverts);
        int  ox;
        int  oy;
        bit  lay;
        bit  last;
        ox  = near_coord();
        oy  = near_coord();
        lay = $urandom;
        for (int v = 0; v < nverts; v++)
        begin
            last = (v == nverts - 1);
            if ($urandom_range(0, 19) == 0)
                last = !last;
            issue(mk(KIND_VERTEX, (v == 0) ? lay : bit'($urandom), ox, oy,
                     int'($urandom_range(0, 4096)) - 2048, int'($urandom_range(0, 4096)) - 2048,
                     $urandom, $urandom, $urandom, last));
        end
    endtask

    // result check
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            n_results++;
            if (pending_flags.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected, got status=%0b hit=%0b wet=%0b",
                         $time, status, hits_obstacle, near_water);
            end
            else
            begin
                if (status !== pending_flags[0][2])
                begin
                    errors++;
                    $display("%0t: status expected %0b actual %0b",
                             $time, pending_flags[0][2], status);
                end
                if (hits_obstacle !== pending_flags[0][1])
                begin
                    errors++;
                    $display("%0t: hits_obstacle expected %0b actual %0b",
                             $time, pending_flags[0][1], hits_obstacle);
                end
                if (near_water !== pending_flags[0][0])
                begin
                    errors++;
                    $display("%0t: near_water expected %0b actual %0b",
                             $time, pending_flags[0][0], near_water);
                end
                n_drops += status;
                n_hits  += hits_obstacle;
                n_wet   += near_water;
                void'(pending_flags.pop_front());
            end
        end
    end

    // watchdog on cycles with nothing taken or answered
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int big;
        int nshapes;
        rst_n       = 1'b0;
        start       = 1'b0;
        kind        = KIND_CLEAR;
        layer       = 1'b0;
        pos_x       = '0;
        pos_y       = '0;
        offset_x    = '0;
        offset_y    = '0;
        rect_width  = '0;
        rect_height = '0;
        radius      = '0;
        last_vertex = 1'b0;
        errors      = 0;
        idle_cycles = 0;
        n_items     = 0;
        n_queries   = 0;
        n_hits      = 0;
        n_wet       = 0;
        n_drops     = 0;
        n_results   = 0;
        sh_nrect    = 0;
        sh_nvert    = 0;
        sh_npoly    = 0;
        sh_open     = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows: empty tables, extremes, saturation, degenerate polygons
        directed_rows.push_back('{mk(KIND_QUERY, 0, 0, 0, 0, 0, 0, 0, 8388607, 0), 1, 3'b000});
        directed_rows.push_back('{mk(KIND_CLEAR, 1, -1, -1, -1, -1, 8388607, 8388607, 8388607, 1),
                                  1, 3'b000});
        directed_rows.push_back('{mk(KIND_RECT, 0, -8388608, -8388608, 0, 0, 8388607, 8388607,
                                     0, 0), 1, 3'b000});
        directed_rows.push_back('{mk(KIND_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 3'b000});
        directed_rows.push_back('{mk(KIND_RECT, 1, 256, 256, 0, 0, 512, 512, 0, 0), 1, 3'b000});
        directed_rows.push_back('{mk(KIND_QUERY, 0, 512, 512, 0, 0, 0, 0, 0, 0), 0, 3'b000});
        directed_rows.push_back('{mk(KIND_QUERY, 0, 8388607, 8388607, 0, 0, 0, 0, 8388607, 0),
                                  0, 3'b000});
        directed_rows.push_back('{mk(KIND_VERTEX, 1, 4096, 0, 0, 0, 0, 0, 0, 0), 1, 3'b000});
        directed_rows.push_back('{mk(KIND_VERTEX, 0, 4096, 0, 1024, -1024, 0, 0, 0, 0), 1, 3'b000});
        directed_rows.push_back('{mk(KIND_QUERY, 0, 4400, 200, 0, 0, 0, 0, 16, 0), 0, 3'b000});
        directed_rows.push_back('{mk(KIND_VERTEX, 0, 4096, 0, 0, -1024, 0, 0, 0, 1), 1, 3'b000});
        directed_rows.push_back('{mk(KIND_QUERY, 0, 4300, 600, 0, 0, 0, 0, 0, 0), 0, 3'b000});
        directed_rows.push_back('{mk(KIND_QUERY, 0, 3900, 500, 0, 0, 0, 0, 300, 0), 0, 3'b000});
        directed_rows.push_back('{mk(KIND_VERTEX, 0, 8388607, 8388607, 8388607, -8388608,
                                     0, 0, 0, 0), 1, 3'b000});
        directed_rows.push_back('{mk(KIND_VERTEX, 1, -8388608, -8388608, -8388608, 8388607,
                                     0, 0, 0, 0), 1, 3'b000});
        directed_rows.push_back('{mk(KIND_VERTEX, 1, -8388608, 8388607, 0, 0, 0, 0, 0, 1),
                                  1, 3'b000});
        directed_rows.push_back('{mk(KIND_QUERY, 0, 0, 0, 0, 0, 0, 0, 1000, 0), 0, 3'b000});
        directed_rows.push_back('{mk(KIND_VERTEX, 1, 100, 100, 0, 0, 0, 0, 0, 0), 1, 3'b000});
        directed_rows.push_back('{mk(KIND_VERTEX, 0, 100, 100, 0, 0, 0, 0, 0, 1), 1, 3'b000});
        directed_rows.push_back('{mk(KIND_VERTEX, 1, -300, -300, 0, 0, 0, 0, 0, 1), 1, 3'b000});
        directed_rows.push_back('{mk(KIND_QUERY, 0, 100, 110, 0, 0, 0, 0, 20, 0), 0, 3'b000});
        directed_rows.push_back('{mk(KIND_QUERY, 0, -8388608, -8388608, 0, 0, 0, 0, 8388607, 0),
                                  0, 3'b000});
        directed_rows.push_back('{mk(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 3'b000});
        directed_rows.push_back('{mk(KIND_QUERY, 1, 0, 0, 0, 0, 0, 0, 8388607, 0), 1, 3'b000});
        foreach (directed_rows[i])
            issue_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want,
                       pick_gap());

        // hold off until the directed part has fully answered
        drain_results();

        // random episodes, each opening with a clear; some fill every table past capacity
        for (int ep = 0; n_items < ITEM_TARGET; ep++)
        begin
            issue(mk(KIND_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom));
            big     = (ep % 6 == 2);
            nshapes = big ? 170 : $urandom_range(2, 14);
            for (int s = 0; s < nshapes; s++)
            begin
                if ($urandom_range(0, 99) < 6)
                    issue(noise_item());
                else if (big ? (s < 75) : ($urandom_range(0, 99) < 40))
                    load_rect();
                else
                    load_polygon(big ? $urandom_range(2, 6) : $urandom_range(1, 6));
                if (!big && $urandom_range(0, 99) < 35)
                    probe_near();
            end
            for (int q = 0; q < (big ? 8 : 6); q++)
                probe_near();
            if (ep % 4 == 3)
                drain_results();
        end

        start <= 1'b0;
        while (pending_flags.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("run: %0d items (%0d queries), %0d results, %0d dropped loads",
                 n_items, n_queries, n_results, n_drops);
        $display("queries hitting a shape: %0d, touching water: %0d", n_hits, n_wet);
        if (errors == 0 && pending_flags.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
